// ===== sv/mhp_pkg.sv =====
// Shared types, constants and decode functions for the MAC header parser.
package mhp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TRUNCATED  = 2'd1,
        ST_RSVD_MODE  = 2'd2,
        ST_IE_VERSION = 2'd3
    } status_t;

    // Address kinds as reported on the result.
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SHORT = 2'd1,
        MODE_EXT   = 2'd2,
        MODE_RSVD  = 2'd3
    } mode_kind_t;

    // Address mode codes as they appear in the frame-control word.
    localparam logic [1:0] CODE_NONE  = 2'd0;
    localparam logic [1:0] CODE_SHORT = 2'd2;
    localparam logic [1:0] CODE_EXT   = 2'd3;

    // Header layout.
    localparam int          POS_W         = 5;
    localparam logic [4:0]  POS_CTL_LO    = 5'd0;
    localparam logic [4:0]  POS_CTL_HI    = 5'd1;
    localparam logic [4:0]  POS_SEQ       = 5'd2;
    localparam logic [4:0]  POS_PAN_LO    = 5'd3;
    localparam logic [4:0]  POS_PAN_HI    = 5'd4;
    localparam logic [4:0]  POS_ADDR      = 5'd5;
    localparam logic [4:0]  MIN_OK_LENGTH = 5'd2;
    localparam logic [1:0]  VERSION_RESET = 2'd2;

    // Map a control-word mode code to the reported address kind.
    function automatic mode_kind_t decode_mode(input logic [1:0] code);
        mode_kind_t kind;
        unique case (code)
            CODE_NONE:  kind = MODE_NONE;
            CODE_SHORT: kind = MODE_SHORT;
            CODE_EXT:   kind = MODE_EXT;
            default:    kind = MODE_RSVD;
        endcase
        return kind;
    endfunction

    // Number of address bytes that an address kind occupies.
    function automatic logic [3:0] mode_bytes(input mode_kind_t kind);
        logic [3:0] n;
        unique case (kind)
            MODE_SHORT: n = 4'd2;
            MODE_EXT:   n = 4'd8;
            default:    n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/mhp_rx_if.sv =====
// Valid/ready channel carrying received frame bytes.
interface mhp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last;

    modport source (output valid, output rx_byte, output last, input ready);
    modport sink   (input valid, input rx_byte, input last, output ready);
endinterface

// ===== sv/mhp_res_if.sv =====
// Valid/ready channel carrying parsed header results.
interface mhp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  frame_type;
    logic [4:0]  flag_bits;
    logic [1:0]  version;
    logic [1:0]  dest_mode;
    logic [1:0]  src_mode;
    logic [7:0]  seq_number;
    logic [15:0] pan_id;
    logic [63:0] dest_address;
    logic [63:0] src_address;
    logic [4:0]  parsed_length;

    modport source (
        output valid, output status, output frame_type, output flag_bits,
        output version, output dest_mode, output src_mode, output seq_number,
        output pan_id, output dest_address, output src_address,
        output parsed_length, input ready
    );
    modport sink (
        input valid, input status, input frame_type, input flag_bits,
        input version, input dest_mode, input src_mode, input seq_number,
        input pan_id, input dest_address, input src_address,
        input parsed_length, output ready
    );
endinterface

// ===== sv/mac_header_parser_unit.sv =====
// Top level of the MAC header parser: byte-wise header parse and result register.
// The parser takes one frame byte per cycle and gives exactly one result per
// frame: when the header (control, sequence number, PAN id and the addresses
// its modes select) is complete, when the control word shows a reserved
// address mode or an IE list with an unexpected frame version, or when the
// last mark arrives early. A result appears in the cycle after the byte that
// completes it and sits in a single output register; rx.ready is low only
// while that register holds a result that has not been taken, so with a
// ready sink the parser sustains one byte per clock. Bytes after a result
// are dropped until the frame's last mark. expected_frame_version resets to 2
// and may be written through cfg_we/cfg_wdata while no frame is in progress.
module mac_header_parser_unit
    import mhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    mhp_rx_if.sink     rx,
    mhp_res_if.source  res
);

    // Parse state.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      cw_reg, cw_next;
    logic [7:0]       seq_reg, seq_next;
    logic [15:0]      pan_reg, pan_next;
    logic [63:0]      dest_reg, dest_next;
    logic [63:0]      src_reg, src_next;
    logic             finished_reg, finished_next;
    logic [1:0]       exp_version_reg;

    // Result register.
    logic             res_valid_reg, res_valid_next;
    status_t          status_reg;
    logic [15:0]      res_cw_reg;
    logic [7:0]       res_seq_reg;
    logic [15:0]      res_pan_reg;
    logic [63:0]      res_dest_reg;
    logic [63:0]      res_src_reg;
    logic [4:0]       res_len_reg;

    // Combinational parse of the incoming byte.
    logic             accept;
    logic             first;
    logic [15:0]      cw_base;
    logic [63:0]      dest_base, src_base;
    logic [3:0]       dlen_old, slen_old, dlen_new, slen_new;
    logic [5:0]       dest_end, src_end;
    logic [4:0]       dest_off, src_off;
    logic [4:0]       used;
    logic [4:0]       total;
    mode_kind_t       dk_new, sk_new;
    logic             emit;
    status_t          emit_status;

    assign rx.ready = !res_valid_reg || res.ready;
    assign accept   = rx.valid && rx.ready;

    // Field capture and result decision for one byte.
    always_comb
    begin
        first     = (pos_reg == POS_CTL_LO);
        cw_base   = first ? 16'd0 : cw_reg;
        dest_base = first ? 64'd0 : dest_reg;
        src_base  = first ? 64'd0 : src_reg;
        cw_next   = cw_base;
        seq_next  = first ? 8'd0 : seq_reg;
        pan_next  = first ? 16'd0 : pan_reg;
        dest_next = dest_base;
        src_next  = src_base;

        dlen_old = mode_bytes(decode_mode(cw_base[11:10]));
        slen_old = mode_bytes(decode_mode(cw_base[15:14]));
        dest_end = 6'(POS_ADDR) + 6'(dlen_old);
        src_end  = dest_end + 6'(slen_old);
        dest_off = pos_reg - POS_ADDR;
        src_off  = pos_reg - POS_ADDR - 5'(dlen_old);

        // Place the byte into the field that owns this position.
        priority if (pos_reg == POS_CTL_LO)
        begin
            cw_next = {8'd0, rx.rx_byte};
        end
        else if (pos_reg == POS_CTL_HI)
        begin
            cw_next = {rx.rx_byte, cw_base[7:0]};
        end
        else if (pos_reg == POS_SEQ)
        begin
            seq_next = rx.rx_byte;
        end
        else if (pos_reg == POS_PAN_LO)
        begin
            pan_next = {8'd0, rx.rx_byte};
        end
        else if (pos_reg == POS_PAN_HI)
        begin
            pan_next = {rx.rx_byte, pan_reg[7:0]};
        end
        else if (6'(pos_reg) < dest_end)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (dest_off[2:0] == 3'(i))
                begin
                    dest_next[8*i +: 8] = dest_base[8*i +: 8] | rx.rx_byte;
                end
            end
        end
        else if (6'(pos_reg) < src_end)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (src_off[2:0] == 3'(i))
                begin
                    src_next[8*i +: 8] = src_base[8*i +: 8] | rx.rx_byte;
                end
            end
        end
        else
        begin
            // Bytes past the address fields are not stored.
            dest_next = dest_base;
        end

        used     = pos_reg + 5'd1;
        dk_new   = decode_mode(cw_next[11:10]);
        sk_new   = decode_mode(cw_next[15:14]);
        dlen_new = mode_bytes(dk_new);
        slen_new = mode_bytes(sk_new);
        total    = POS_ADDR + 5'(dlen_new) + 5'(slen_new);

        // Control-word errors first, then completion, then early end.
        emit        = 1'b1;
        emit_status = ST_OK;
        priority if (pos_reg == POS_CTL_HI && cw_next[9] &&
                     cw_next[13:12] != exp_version_reg)
        begin
            emit_status = ST_IE_VERSION;
        end
        else if (pos_reg == POS_CTL_HI && (dk_new == MODE_RSVD || sk_new == MODE_RSVD))
        begin
            emit_status = ST_RSVD_MODE;
        end
        else if (used >= MIN_OK_LENGTH && used >= total)
        begin
            emit_status = ST_OK;
        end
        else if (rx.last)
        begin
            emit_status = ST_TRUNCATED;
        end
        else
        begin
            emit = 1'b0;
        end

        // Position and end-of-header tracking.
        pos_next      = pos_reg;
        finished_next = finished_reg;
        if (accept)
        begin
            if (finished_reg)
            begin
                if (rx.last)
                begin
                    finished_next = 1'b0;
                    pos_next      = POS_CTL_LO;
                end
            end
            else if (emit && rx.last)
            begin
                finished_next = 1'b0;
                pos_next      = POS_CTL_LO;
            end
            else
            begin
                finished_next = emit;
                pos_next      = used;
            end
        end

        res_valid_next = (accept && !finished_reg && emit) ||
                         (res_valid_reg && !res.ready);
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= POS_CTL_LO;
            finished_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
            exp_version_reg <= VERSION_RESET;
            cw_reg          <= 16'd0;
            seq_reg         <= 8'd0;
            pan_reg         <= 16'd0;
            dest_reg        <= 64'd0;
            src_reg         <= 64'd0;
        end
        else
        begin
            pos_reg       <= pos_next;
            finished_reg  <= finished_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                exp_version_reg <= cfg_wdata;
            end
            if (accept && !finished_reg)
            begin
                cw_reg   <= cw_next;
                seq_reg  <= seq_next;
                pan_reg  <= pan_next;
                dest_reg <= dest_next;
                src_reg  <= src_next;
            end
        end
    end

    // Result payload, loaded when a transaction produces a result.
    always_ff @(posedge clk)
    begin
        if (accept && !finished_reg && emit)
        begin
            status_reg   <= emit_status;
            res_cw_reg   <= cw_next;
            res_seq_reg  <= seq_next;
            res_pan_reg  <= pan_next;
            res_dest_reg <= dest_next;
            res_src_reg  <= src_next;
            res_len_reg  <= used;
        end
    end

    // Decode the captured control word onto the result fields.
    mode_kind_t res_dk, res_sk;
    assign res_dk = decode_mode(res_cw_reg[11:10]);
    assign res_sk = decode_mode(res_cw_reg[15:14]);

    assign res.valid         = res_valid_reg;
    assign res.status        = status_reg;
    assign res.frame_type    = res_cw_reg[2:0];
    assign res.flag_bits     = {res_cw_reg[9], res_cw_reg[6:3]};
    assign res.version       = res_cw_reg[13:12];
    assign res.dest_mode     = (res_dk == MODE_RSVD) ? MODE_NONE : res_dk;
    assign res.src_mode      = (res_sk == MODE_RSVD) ? MODE_NONE : res_sk;
    assign res.seq_number    = res_seq_reg;
    assign res.pan_id        = res_pan_reg;
    assign res.dest_address  = res_dest_reg;
    assign res.src_address   = res_src_reg;
    assign res.parsed_length = res_len_reg;

endmodule

// ===== sv/mhp_checker.sv =====
// Port-level checks on the MAC header parser, bound to its top level.
module mhp_checker
    import mhp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_status,
    input logic [1:0] res_dest_mode,
    input logic [1:0] res_src_mode,
    input logic [4:0] res_parsed_length
);

    // A result that is not taken stays offered with the same status.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_status))
        else $error("result dropped or changed while stalled");

    // Control-word errors are found exactly at the second byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_RSVD_MODE || res_status == ST_IE_VERSION)
        |-> res_parsed_length == 5'd2)
        else $error("control-word error reported at the wrong length");

    // A complete header has at least the fixed fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_OK |-> res_parsed_length >= POS_ADDR)
        else $error("header reported complete too early");

    // Header length stays in range and reserved modes are never shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_parsed_length != 5'd0 && res_parsed_length <= 5'd21 &&
                      res_dest_mode != MODE_RSVD && res_src_mode != MODE_RSVD)
        else $error("result fields out of range");

endmodule

bind mac_header_parser_unit mhp_checker u_mhp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_status        (res.status),
    .res_dest_mode     (res.dest_mode),
    .res_src_mode      (res.src_mode),
    .res_parsed_length (res.parsed_length)
);

// ===== test/mac_header_parser_unit_check.sv =====
// Checker for the MAC header parser: predicts each header result and compares it.
`timescale 1ns / 100ps

module mac_header_parser_unit_check
    import mhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    mhp_rx_if           rx,
    mhp_res_if          res,
    output int unsigned fail_count,
    output int unsigned pending_count
);

    // One parsed header result, laid out as on the result channel.
    typedef struct packed {
        status_t     status;
        logic [2:0]  frame_type;
        logic [4:0]  flag_bits;
        logic [1:0]  version;
        mode_kind_t  dest_mode;
        mode_kind_t  src_mode;
        logic [7:0]  seq_number;
        logic [15:0] pan_id;
        logic [63:0] dest_address;
        logic [63:0] src_address;
        logic [4:0]  parsed_length;
    } header_result_t;

    // Shadow copy of the parser state and its version register.
    logic [4:0]  frame_pos;
    logic [15:0] frame_ctl;
    logic [7:0]  frame_seq;
    logic [15:0] frame_pan;
    logic [63:0] frame_dest;
    logic [63:0] frame_src;
    logic        header_done;
    logic [1:0]  required_version;

    header_result_t expected_headers[$];
    int unsigned    mismatches;

    // Address kind selected by a control-word mode code.
    function automatic mode_kind_t addr_kind(input logic [1:0] code);
        case (code)
            CODE_NONE:  return MODE_NONE;
            CODE_SHORT: return MODE_SHORT;
            CODE_EXT:   return MODE_EXT;
            default:    return MODE_RSVD;
        endcase
    endfunction

    // Number of address bytes in the frame for a mode code.
    function automatic int addr_len(input logic [1:0] code);
        case (addr_kind(code))
            MODE_SHORT: return 2;
            MODE_EXT:   return 8;
            default:    return 0;
        endcase
    endfunction

    // Advance the shadow parser by one byte; returns 1 when a result is due.
    function automatic bit parse_rx_byte(input logic [7:0] b, input logic lst,
                                         output header_result_t hdr);
        logic [4:0] p;
        logic [4:0] used;
        int         dlen;
        int         slen;
        int         off;
        bit         due;
        status_t    st;
        mode_kind_t dk;
        mode_kind_t sk;

        hdr = '0;
        due = 1'b0;
        st  = ST_OK;

        // Bytes after the result only wait for the frame's last mark.
        if (header_done)
        begin
            if (lst)
            begin
                header_done = 1'b0;
                frame_pos   = '0;
            end
            return 1'b0;
        end

        p = frame_pos;
        if (p == POS_CTL_LO)
        begin
            frame_ctl  = '0;
            frame_seq  = '0;
            frame_pan  = '0;
            frame_dest = '0;
            frame_src  = '0;
        end

        dlen = addr_len(frame_ctl[11:10]);
        slen = addr_len(frame_ctl[15:14]);

        // Store the byte in the field that its position selects.
        if (p == POS_CTL_LO)
            frame_ctl[7:0] = b;
        else if (p == POS_CTL_HI)
            frame_ctl[15:8] = b;
        else if (p == POS_SEQ)
            frame_seq = b;
        else if (p == POS_PAN_LO)
            frame_pan[7:0] = b;
        else if (p == POS_PAN_HI)
            frame_pan[15:8] = b;
        else if (int'(p) < 5 + dlen)
        begin
            off = (int'(p) - 5) & 7;
            frame_dest = frame_dest | ({56'd0, b} << (off * 8));
        end
        else if (int'(p) < 5 + dlen + slen)
        begin
            off = (int'(p) - 5 - dlen) & 7;
            frame_src = frame_src | ({56'd0, b} << (off * 8));
        end
        used      = p + 5'd1;
        frame_pos = used;

        dk = addr_kind(frame_ctl[11:10]);
        sk = addr_kind(frame_ctl[15:14]);

        // Control-word errors are decided at the second control byte.
        if (p == POS_CTL_HI)
        begin
            if (frame_ctl[9] && frame_ctl[13:12] != required_version)
            begin
                st  = ST_IE_VERSION;
                due = 1'b1;
            end
            else if (dk == MODE_RSVD || sk == MODE_RSVD)
            begin
                st  = ST_RSVD_MODE;
                due = 1'b1;
            end
        end

        // Otherwise a complete header or an early last mark ends the parse.
        if (!due)
        begin
            dlen = addr_len(frame_ctl[11:10]);
            slen = addr_len(frame_ctl[15:14]);
            if (used >= MIN_OK_LENGTH && int'(used) >= 5 + dlen + slen)
            begin
                st  = ST_OK;
                due = 1'b1;
            end
            else if (lst)
            begin
                st  = ST_TRUNCATED;
                due = 1'b1;
            end
        end

        if (due)
        begin
            hdr.status        = st;
            hdr.frame_type    = frame_ctl[2:0];
            hdr.flag_bits     = {frame_ctl[9], frame_ctl[6], frame_ctl[5], frame_ctl[4],
                                 frame_ctl[3]};
            hdr.version       = frame_ctl[13:12];
            hdr.dest_mode     = (dk == MODE_RSVD) ? MODE_NONE : dk;
            hdr.src_mode      = (sk == MODE_RSVD) ? MODE_NONE : sk;
            hdr.seq_number    = frame_seq;
            hdr.pan_id        = frame_pan;
            hdr.dest_address  = frame_dest;
            hdr.src_address   = frame_src;
            hdr.parsed_length = used;
            if (lst)
            begin
                header_done = 1'b0;
                frame_pos   = '0;
            end
            else
                header_done = 1'b1;
        end
        return due;
    endfunction

    // Compare one field of a result transaction.
    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Follow register writes, byte transactions and result transactions.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        header_result_t predicted;
        header_result_t oldest;

        if (!rst_n)
        begin
            frame_pos        = '0;
            frame_ctl        = '0;
            frame_seq        = '0;
            frame_pan        = '0;
            frame_dest       = '0;
            frame_src        = '0;
            header_done      = 1'b0;
            required_version = VERSION_RESET;
            expected_headers.delete();
        end
        else
        begin
            if (cfg_we)
                required_version = cfg_wdata;

            if (rx.valid === 1'b1 && rx.ready === 1'b1)
            begin
                if (parse_rx_byte(rx.rx_byte, rx.last, predicted))
                    expected_headers.push_back(predicted);
            end

            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                if (expected_headers.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual status %0h length %0d",
                             $time, res.status, res.parsed_length);
                end
                else
                begin
                    oldest = expected_headers.pop_front();
                    compare_field("status", 64'(oldest.status), 64'(res.status));
                    compare_field("frame_type", 64'(oldest.frame_type),
                                  64'(res.frame_type));
                    compare_field("flag_bits", 64'(oldest.flag_bits), 64'(res.flag_bits));
                    compare_field("version", 64'(oldest.version), 64'(res.version));
                    compare_field("dest_mode", 64'(oldest.dest_mode), 64'(res.dest_mode));
                    compare_field("src_mode", 64'(oldest.src_mode), 64'(res.src_mode));
                    compare_field("seq_number", 64'(oldest.seq_number),
                                  64'(res.seq_number));
                    compare_field("pan_id", 64'(oldest.pan_id), 64'(res.pan_id));
                    compare_field("dest_address", oldest.dest_address, res.dest_address);
                    compare_field("src_address", oldest.src_address, res.src_address);
                    compare_field("parsed_length", 64'(oldest.parsed_length),
                                  64'(res.parsed_length));
                end
            end
        end

        fail_count    <= mismatches;
        pending_count <= expected_headers.size();
    end

    initial
    begin
        mismatches    = 0;
        fail_count    = 0;
        pending_count = 0;
    end

endmodule

// ===== test/mac_header_parser_unit_tb.sv =====
// Testbench top for the MAC header parser: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module mac_header_parser_unit_tb;
    import mhp_pkg::*;

    // Mode code that the standard leaves reserved.
    localparam logic [1:0] CODE_RESERVED = 2'd1;
    localparam int         PHASE_COUNT   = 7;
    localparam int         PHASE_BYTES   = 230;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    int unsigned fail_count;
    int unsigned pending_count;

    logic [7:0]  frame_q[$];
    logic [1:0]  active_version;
    bit          gaps_on;
    int          stall_left;

    mhp_rx_if  rx_ch ();
    mhp_res_if res_ch ();

    mac_header_parser_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    mac_header_parser_unit_check header_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .rx            (rx_ch),
        .res           (res_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    // Result sink: ready drops in random bursts while gaps are enabled.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            res_ch.ready  <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left    <= $urandom_range(0, 14);
            res_ch.ready  <= 1'b0;
        end
        else
            res_ch.ready  <= 1'b1;
    end

    // Send one byte transaction, sometimes after an idle burst.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        rx_ch.last    <= lst;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    // Send the queued frame with the last mark on its final byte.
    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    // Stop sending and wait until every expected result has been taken.
    task automatic drain_results();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the expected frame version while the parser is idle.
    task automatic write_version(input logic [1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_version = v;
    endtask

    function automatic logic [1:0] pick_code();
        case ($urandom_range(0, 2))
            0:       return CODE_NONE;
            1:       return CODE_SHORT;
            default: return CODE_EXT;
        endcase
    endfunction

    function automatic int code_len(input logic [1:0] code);
        if (code == CODE_EXT)
            return 8;
        if (code == CODE_SHORT)
            return 2;
        return 0;
    endfunction

    // Build a random frame: mostly well-formed headers, some broken, some noise.
    task automatic build_frame();
        logic [1:0] dcode;
        logic [1:0] scode;
        logic [1:0] ver;
        logic       ie;
        int         kind;
        int         hdr_len;
        int         cut;

        frame_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
        end
        else
        begin
            dcode = pick_code();
            scode = pick_code();
            ie    = 1'($urandom);
            ver   = 2'($urandom);
            if (ie && $urandom_range(0, 3) != 0)
                ver = active_version;
            if (kind < 27)
            begin
                if ($urandom_range(0, 1) == 0)
                    dcode = CODE_RESERVED;
                else
                    scode = CODE_RESERVED;
            end
            hdr_len = 5 + code_len(dcode) + code_len(scode);
            frame_q.push_back(8'($urandom));
            frame_q.push_back({scode, ver, dcode, ie, 1'($urandom)});
            repeat (hdr_len - 2) frame_q.push_back(8'($urandom));

            // Cut some frames short; pad the rest with ignored payload.
            if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, hdr_len - 1);
                frame_q = frame_q[0:cut-1];
            end
            else
                repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        int sent;

        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        rx_ch.last     = 1'b0;
        res_ch.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        stall_left     = 0;
        gaps_on        = 1'b1;
        active_version = VERSION_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // A one-byte frame ends before the header: truncated at length one.
        frame_q = '{8'h00};
        send_frame();

        // Reserved source mode on a last second byte: the error wins.
        frame_q = '{8'h5A, 8'h40};
        send_frame();

        // IE list with version 1 against the reset version, then an ignored byte.
        frame_q = '{8'h00, 8'h12, 8'hAB};
        send_frame();

        // Longest header: all flags, both addresses extended, matching version.
        frame_q.delete();
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'hEE);
        repeat (18) frame_q.push_back(8'hFF);
        frame_q.push_back(8'h00);
        send_frame();

        // Random phases, each under its own expected version.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            drain_results();
            case (ph)
                0:       write_version(2'd3);
                1:       write_version(2'd0);
                2:       write_version(2'd1);
                3:       write_version(2'd2);
                6:       write_version(2'd3);
                default: write_version(2'($urandom));
            endcase
            gaps_on = (ph != 2 && ph != PHASE_COUNT - 1);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_frame();
                send_frame();
                sent += frame_q.size();
            end
        end

        drain_results();
        if (fail_count == 0 && pending_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/mhp_pkg.sv
sv/mhp_rx_if.sv
sv/mhp_res_if.sv
sv/mac_header_parser_unit.sv
sv/mhp_checker.sv
test/mac_header_parser_unit_check.sv
test/mac_header_parser_unit_tb.sv
